FILE: hdl/caft_pkg.sv
// ----------------------------------------------------------------------------
// caft_pkg
// shared constants and controller/datapath interface types for the
// candidate address frequency table
// ----------------------------------------------------------------------------
package caft_pkg;

	localparam int TABLE_ENTRIES = 10;
	localparam int ADDR_W        = 32;
	localparam int HIT_W         = 3;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam logic [HIT_W-1:0] CAP_RESET  = HIT_W'(5);
	localparam logic [HIT_W-1:0] HIT_NEW    = HIT_W'(1);
	localparam logic [HIT_W-1:0] HIT_CLEAR  = '0;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] HALF_COUNT = CNT_W'(TABLE_ENTRIES / 2);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] LAST_PIVOT = IDX_W'(TABLE_ENTRIES - 2);

	localparam logic MODE_OBSERVE = 1'b0;
	localparam logic MODE_CLEAR   = 1'b1;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic clear;
		logic update;
		logic append;
		logic sort_init;
		logic load;
		logic sweep;
		logic store;
		logic halve;
		logic result;
	} caft_cmd_t;

	typedef struct packed {
		logic clear_req;
		logic found;
		logic full;
		logic last_j;
		logic last_i;
		logic out_free;
	} caft_status_t;

endpackage

FILE: hdl/candidate_address_frequency_table.sv
// ----------------------------------------------------------------------------
// candidate_address_frequency_table
// frequency table of observed 32-bit addresses with saturating hit counts
// ----------------------------------------------------------------------------
// One item at a time. An item that hits or appends passes through accept,
// lookup, update or append, and result load; an item in clear mode empties
// the table at lookup and goes on to result load. An item that finds the
// table full first runs the exchange sort, one compare-exchange per cycle
// against a held pivot, with a load, sweep and store for each pivot, and the
// table is then cut to its higher-count half before the append. A finished
// result sits in the output register, and the next item is accepted while it
// waits. count_cap may be written at any time the block is idle; cfg_ready is always high.
module candidate_address_frequency_table import caft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [HIT_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [HIT_W-1:0]  hit_count,
	output logic              repeated,
	output logic              table_pruned
);

	caft_cmd_t    cmd;
	caft_status_t status;

	assign cfg_ready = 1'b1;

	caft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	caft_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.address      (address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit_count    (hit_count),
		.repeated     (repeated),
		.table_pruned (table_pruned)
	);

	// one item in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while previous item in progress");

	// a pruned table always appends the new address with count one
	a_pruned_is_new: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_pruned) |-> (hit_count == HIT_NEW))
		else $error("pruned result without new entry count");

	// at most one table access command per cycle
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.update, cmd.append, cmd.load, cmd.sweep, cmd.store, cmd.clear}))
		else $error("conflicting table commands");

	// a result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> (!out_valid || out_ready))
		else $error("result overwrites pending output");

endmodule

FILE: hdl/caft_ctrl.sv
// ----------------------------------------------------------------------------
// caft_ctrl
// sequencer for lookup, update, append and the exchange sort that prunes
// a full table
// ----------------------------------------------------------------------------
module caft_ctrl import caft_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  caft_status_t status,
	output caft_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_SWEEP  = 3'd4;
	localparam logic [2:0] ST_STORE  = 3'd5;
	localparam logic [2:0] ST_APPEND = 3'd6;
	localparam logic [2:0] ST_RESULT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (status.clear_req) begin
					cmd.clear = 1'b1;
					state_d   = ST_RESULT;
				end else if (status.found) begin
					state_d = ST_UPDATE;
				end else if (status.full) begin
					cmd.sort_init = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.last_j) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (status.last_i) begin
					cmd.halve = 1'b1;
					state_d   = ST_APPEND;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/caft_dpath.sv
// ----------------------------------------------------------------------------
// caft_dpath
// address and count storage, parallel lookup, compare-exchange unit for the
// sort, count cap register and result register
// ----------------------------------------------------------------------------
module caft_dpath import caft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  caft_cmd_t         cmd,
	output caft_status_t      status,
	input  logic              cfg_valid,
	input  logic [HIT_W-1:0]  cfg_data,
	input  logic              mode,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [HIT_W-1:0]  hit_count,
	output logic              repeated,
	output logic              table_pruned
);

	logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
	logic [HIT_W-1:0]  cnt_mem  [TABLE_ENTRIES];

	logic              mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [HIT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  used_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [ADDR_W-1:0] hold_addr_q;
	logic [HIT_W-1:0]  hold_cnt_q;
	logic [HIT_W-1:0]  hit_q;
	logic              pruned_q;
	logic              out_valid_q;
	logic [HIT_W-1:0]  out_hit_q;
	logic              out_rep_q;
	logic              out_pruned_q;

	logic              found_c;
	logic [IDX_W-1:0]  match_idx_c;
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [HIT_W-1:0]  rd_cnt;
	logic [HIT_W-1:0]  new_cnt;
	logic              swap;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [ADDR_W-1:0] wr_addr;
	logic [HIT_W-1:0]  wr_cnt;

	// lowest matching valid entry
	always_comb begin
		found_c     = 1'b0;
		match_idx_c = '0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if ((addr_mem[k] == addr_q) && (CNT_W'(k) < used_q)) begin
				found_c     = 1'b1;
				match_idx_c = IDX_W'(k);
			end
		end
	end

	// single read port
	always_comb begin
		if (cmd.load) begin
			rd_idx = i_q;
		end else if (cmd.sweep) begin
			rd_idx = j_q;
		end else begin
			rd_idx = idx_q;
		end
	end

	assign rd_addr = addr_mem[rd_idx];
	assign rd_cnt  = cnt_mem[rd_idx];
	assign new_cnt = (rd_cnt < cap_q) ? rd_cnt + HIT_W'(1) : rd_cnt;
	assign swap    = cmd.sweep && (hold_cnt_q < rd_cnt);

	// single write port
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_addr = rd_addr;
		wr_cnt  = new_cnt;
		if (swap) begin
			wr_en   = 1'b1;
			wr_idx  = j_q;
			wr_addr = hold_addr_q;
			wr_cnt  = hold_cnt_q;
		end else if (cmd.store) begin
			wr_en   = 1'b1;
			wr_idx  = i_q;
			wr_addr = hold_addr_q;
			wr_cnt  = hold_cnt_q;
		end else if (cmd.update) begin
			wr_en   = 1'b1;
		end else if (cmd.append) begin
			wr_en   = 1'b1;
			wr_idx  = used_q[IDX_W-1:0];
			wr_addr = addr_q;
			wr_cnt  = HIT_NEW;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[wr_idx] <= wr_addr;
			cnt_mem[wr_idx]  <= wr_cnt;
		end
	end

	// item payload and sort working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			addr_q <= address;
		end
		if (cmd.lookup) begin
			idx_q <= match_idx_c;
		end
		if (cmd.sort_init) begin
			i_q <= '0;
		end else if (cmd.store) begin
			i_q <= IDX_W'(i_q + 1'b1);
		end
		if (cmd.load) begin
			j_q         <= IDX_W'(i_q + 1'b1);
			hold_addr_q <= rd_addr;
			hold_cnt_q  <= rd_cnt;
		end else if (cmd.sweep) begin
			j_q <= IDX_W'(j_q + 1'b1);
			if (swap) begin
				hold_addr_q <= rd_addr;
				hold_cnt_q  <= rd_cnt;
			end
		end
		if (cmd.clear) begin
			hit_q <= HIT_CLEAR;
		end else if (cmd.update) begin
			hit_q <= new_cnt;
		end else if (cmd.append) begin
			hit_q <= HIT_NEW;
		end
		if (cmd.result) begin
			out_hit_q    <= hit_q;
			out_rep_q    <= (hit_q > HIT_W'(1));
			out_pruned_q <= pruned_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			used_q      <= '0;
			pruned_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.clear) begin
				used_q <= '0;
			end else if (cmd.halve) begin
				used_q <= HALF_COUNT;
			end else if (cmd.append) begin
				used_q <= CNT_W'(used_q + 1'b1);
			end
			if (cmd.capture) begin
				pruned_q <= 1'b0;
			end else if (cmd.sort_init) begin
				pruned_q <= 1'b1;
			end
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.clear_req = (mode_q == MODE_CLEAR);
	assign status.found     = found_c;
	assign status.full      = (used_q == FULL_COUNT);
	assign status.last_j    = (j_q == LAST_IDX);
	assign status.last_i    = (i_q == LAST_PIVOT);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign hit_count    = out_hit_q;
	assign repeated     = out_rep_q;
	assign table_pruned = out_pruned_q;

endmodule
